### src/lr_pkg.sv
package lr_pkg;

  localparam int COORD_BITS = 6;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // One classified line segment, as handed from front to back.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    coord_t dx;       // |end_x - start_x|
    coord_t dy;       // |end_y - start_y|
    logic   x_dec;    // x walks downward
    logic   y_dec;    // y walks downward
  } line_desc_t;

endpackage

### src/line_rasterizer_top.sv
// Bresenham line walker, all octants, one pixel beat per cycle unless the output is held.
// The first pixel of a pushed line passes the line queue, the walker registers and
// the output beat register. A line has N pixels (N = max(|dx|,|dy|)+1, up to 64);
// the next segment loads from the 2-entry line queue after the last pixel, with no pixel out.
// Reset (rst_n low, synchronous) empties the line queue and the output register.
module line_rasterizer_top
  import lr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  output logic   full,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  output logic   empty,
  input  logic   pop,
  output coord_t out_pixel_x,
  output coord_t out_pixel_y,
  output logic   out_is_start_point,
  output logic   out_last_pixel
);

  line_desc_t front_desc, q_desc;
  logic       q_empty, q_take;

  lr_front u_front (
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .desc    (front_desc)
  );

  lr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_desc),
    .q_full  (full),
    .rd_en   (q_take),
    .rd_data (q_desc),
    .q_empty (q_empty)
  );

  lr_walker u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .desc           (q_desc),
    .desc_empty     (q_empty),
    .desc_take      (q_take),
    .empty          (empty),
    .pop            (pop),
    .pixel_x        (out_pixel_x),
    .pixel_y        (out_pixel_y),
    .is_start_point (out_is_start_point),
    .last_pixel     (out_last_pixel)
  );

endmodule

### src/lr_front.sv
module lr_front
  import lr_pkg::*;
(
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  output line_desc_t desc
);

  always_comb begin
    desc.start_x = start_x;
    desc.start_y = start_y;
    desc.end_x   = end_x;
    desc.end_y   = end_y;
    desc.x_dec   = (end_x < start_x);
    desc.y_dec   = (end_y < start_y);
    desc.dx      = desc.x_dec ? (start_x - end_x) : (end_x - start_x);
    desc.dy      = desc.y_dec ? (start_y - end_y) : (end_y - start_y);
  end

endmodule

### src/lr_queue.sv
module lr_queue
  import lr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  line_desc_t wr_data,
  output logic       q_full,
  input  logic       rd_en,
  output line_desc_t rd_data,
  output logic       q_empty
);

  line_desc_t mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign q_full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr_r];

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_wr ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

endmodule

### src/lr_walker.sv
module lr_walker
  import lr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  line_desc_t desc,
  input  logic       desc_empty,
  output logic       desc_take,
  output logic       empty,
  input  logic       pop,
  output coord_t     pixel_x,
  output coord_t     pixel_y,
  output logic       is_start_point,
  output logic       last_pixel
);

  logic   busy_r, busy_nxt;
  logic   first_r, first_nxt;
  coord_t cx_r, cx_nxt, cy_r, cy_nxt;
  coord_t tx_r, tx_nxt, ty_r, ty_nxt;
  err_t   dx_r, dx_nxt, dy_r, dy_nxt;   // dy_r holds -|dy|
  logic   x_dec_r, x_dec_nxt, y_dec_r, y_dec_nxt;
  err_t   err_r, err_nxt;

  logic   ov_r, ov_nxt;
  coord_t ox_r, ox_nxt, oy_r, oy_nxt;
  logic   os_r, os_nxt, ol_r, ol_nxt;

  logic   adv, done, step_x, step_y;
  err_t   e2, ld_dx, ld_dy;

  assign adv       = busy_r && (!ov_r || pop);
  assign done      = (cx_r == tx_r) && (cy_r == ty_r);
  assign e2        = err_r <<< 1;
  assign step_x    = (e2 >= dy_r);
  assign step_y    = (e2 <= dx_r);
  assign desc_take = !busy_r && !desc_empty;
  assign ld_dx     = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, desc.dx});
  assign ld_dy     = -$signed({{(ERR_BITS-COORD_BITS){1'b0}}, desc.dy});

  assign empty          = !ov_r;
  assign pixel_x        = ox_r;
  assign pixel_y        = oy_r;
  assign is_start_point = os_r;
  assign last_pixel     = ol_r;

  always_comb begin
    busy_nxt  = busy_r;
    first_nxt = first_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    x_dec_nxt = x_dec_r;
    y_dec_nxt = y_dec_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && !pop;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    os_nxt    = os_r;
    ol_nxt    = ol_r;

    if (desc_take) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      cx_nxt    = desc.start_x;
      cy_nxt    = desc.start_y;
      tx_nxt    = desc.end_x;
      ty_nxt    = desc.end_y;
      dx_nxt    = ld_dx;
      dy_nxt    = ld_dy;
      x_dec_nxt = desc.x_dec;
      y_dec_nxt = desc.y_dec;
      err_nxt   = ld_dx + ld_dy;
    end else if (adv) begin
      // emit current pixel into the output beat register, then step
      ov_nxt    = 1'b1;
      ox_nxt    = cx_r;
      oy_nxt    = cy_r;
      os_nxt    = first_r;
      ol_nxt    = done;
      first_nxt = 1'b0;
      if (done) begin
        busy_nxt = 1'b0;
      end else begin
        err_nxt = err_r + (step_x ? dy_r : '0) + (step_y ? dx_r : '0);
        if (step_x) cx_nxt = x_dec_r ? cx_r - 1'b1 : cx_r + 1'b1;
        if (step_y) cy_nxt = y_dec_r ? cy_r - 1'b1 : cy_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    x_dec_r <= x_dec_nxt;
    y_dec_r <= y_dec_nxt;
    err_r   <= err_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    os_r    <= os_nxt;
    ol_r    <= ol_nxt;
  end

endmodule
